@@ sv/pcdq_pkg.sv @@
// Shared types, constants and elaboration-time functions for the phase current to dq unit.
`timescale 1ns / 1ps
`default_nettype none

package pcdq_pkg;

	localparam int DEFAULT_SINE_ADDR_BITS = 10;
	localparam int DEFAULT_SAMPLE_BITS    = 12;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [11:0] OFFSET_RESET = 12'd2048;
	localparam logic [15:0] COEF_RESET   = 16'd37837;

	// pi/2 in Q30
	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

	// Taylor series divisors (2k)(2k+1) for k = 1..8
	localparam logic [63:0] SERIES_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_U_OFFSET = 2'd0,
		CFG_V_OFFSET = 2'd1,
		CFG_W_OFFSET = 2'd2,
		CFG_COEF     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] u_sample;
		logic [11:0] v_sample;
		logic [11:0] w_sample;
		logic [2:0]  sector;
		logic [15:0] rotor_angle;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] phase_a;
		logic signed [15:0] phase_b;
		logic signed [15:0] phase_c;
		logic signed [15:0] alpha_current;
		logic signed [15:0] beta_current;
		logic signed [15:0] direct_current;
		logic signed [15:0] quadrature_current;
	} result_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// Rebuild one phase from the other two: -(x + y), saturated
	function automatic logic signed [15:0] kcl(input logic signed [15:0] x,
		input logic signed [15:0] y);
		logic signed [19:0] s;
		s = -20'(x) - 20'(y);
		return sat16(s);
	endfunction

	// Quarter-wave sine entry, trunc(32768*sin(pi/2*i/2^qb)), Q30 series, used at elaboration
	function automatic logic [15:0] quarter_sine(input int unsigned i, input int unsigned qb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		if (i == 0) begin
			return 16'd0;
		end
		if (i >= (32'd1 << qb)) begin
			return 16'd32768;
		end
		x    = (64'(i) * PIHALF_Q30) >> qb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / SERIES_DIV[k-1];
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (longint'(1) << 30)) begin
			sum = longint'(1) << 30;
		end
		return 16'(sum >>> 15);
	endfunction

endpackage

`default_nettype wire

@@ sv/phase_current_to_dq_unit.sv @@
// Top level: phase current reconstruction, Clarke and Park transforms in a five-stage pipeline.
//
// Usage:
//   sample channel : sample_valid / sample_stall / sample (three raw ADC samples,
//                    SVPWM sector, rotor angle). A transfer happens when valid is
//                    high and stall is low.
//   result channel : result_valid / result_stall / result (phase currents, alpha,
//                    beta, d, q, all Q15 signed).
//   config channel : cfg_valid / cfg_ready / cfg_addr / cfg_wdata, always ready;
//                    write only while no sample is in flight.
// Each sample passes through the five register stages s1 to s5; result_valid is the
// s5 valid bit. Throughput is one sample per cycle while result_stall is low or no
// result waits; the five register stages advance together, so the rate is set by
// the single pipeline enable. When result_stall is high with a result waiting, the
// whole pipeline holds and sample_stall goes high; nothing is dropped or duplicated.
// Reset clears all stage valid bits and loads offsets of 2048 and a coefficient
// of 37837 (1/sqrt(3) in Q16). The sine table is constant logic, no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module phase_current_to_dq_unit
	import pcdq_pkg::*;
#(
	parameter int SINE_ADDR_BITS = DEFAULT_SINE_ADDR_BITS,
	parameter int SAMPLE_BITS    = DEFAULT_SAMPLE_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      sample_valid,
	output      logic                      sample_stall,
	input  wire sample_t                   sample,
	output      logic                      result_valid,
	input  wire logic                      result_stall,
	output      result_t                   result,
	input  wire logic                      cfg_valid,
	output      logic                      cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	localparam int QUAD_BITS = SINE_ADDR_BITS - 2;
	localparam int QUAD_SIZE = 1 << QUAD_BITS;
	localparam int SHIFT     = 15 - SAMPLE_BITS;

	// configuration
	logic [11:0] u_offset_q, v_offset_q, w_offset_q;
	logic [15:0] coef_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_offset_q <= OFFSET_RESET;
			v_offset_q <= OFFSET_RESET;
			w_offset_q <= OFFSET_RESET;
			coef_q     <= COEF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_U_OFFSET: u_offset_q <= cfg_wdata[11:0];
				CFG_V_OFFSET: v_offset_q <= cfg_wdata[11:0];
				CFG_W_OFFSET: w_offset_q <= cfg_wdata[11:0];
				CFG_COEF:     coef_q     <= cfg_wdata;
			endcase
		end
	end

	// quarter-wave sine table, built at elaboration
	logic [15:0] sine_rom [QUAD_SIZE];

	for (genvar g = 0; g < QUAD_SIZE; g++) begin : g_rom
		assign sine_rom[g] = quarter_sine(g, QUAD_BITS);
	end

	// pipeline enable: everything moves unless a finished result is held
	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign adv          = !(valid_s5 && result_stall);
	assign sample_stall = !adv;
	assign result_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: offset removal, scaling, sine/cosine table index
	logic signed [SAMPLE_BITS:0]    du, dv, dw;
	logic [SINE_ADDR_BITS-1:0]      ang_idx;
	logic [1:0]                     quad_sin, quad_cos;
	logic [QUAD_BITS-1:0]           quad_off;
	logic [QUAD_BITS:0]             sin_idx, cos_idx;

	logic signed [15:0]   ra_s1, rb_s1, rc_s1;
	logic [2:0]           sector_s1;
	logic [QUAD_BITS:0]   sin_idx_s1, cos_idx_s1;
	logic                 sin_neg_s1, cos_neg_s1;

	always_comb begin
		du = $signed({1'b0, u_offset_q[SAMPLE_BITS-1:0]})
			- $signed({1'b0, sample.u_sample[SAMPLE_BITS-1:0]});
		dv = $signed({1'b0, v_offset_q[SAMPLE_BITS-1:0]})
			- $signed({1'b0, sample.v_sample[SAMPLE_BITS-1:0]});
		dw = $signed({1'b0, w_offset_q[SAMPLE_BITS-1:0]})
			- $signed({1'b0, sample.w_sample[SAMPLE_BITS-1:0]});
		ang_idx  = sample.rotor_angle[15 -: SINE_ADDR_BITS];
		quad_sin = ang_idx[SINE_ADDR_BITS-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		quad_off = ang_idx[QUAD_BITS-1:0];
		// odd quadrants run the table backward
		sin_idx = quad_sin[0] ? ((QUAD_BITS+1)'(QUAD_SIZE) - {1'b0, quad_off})
			: {1'b0, quad_off};
		cos_idx = quad_cos[0] ? ((QUAD_BITS+1)'(QUAD_SIZE) - {1'b0, quad_off})
			: {1'b0, quad_off};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s1      <= {du, {SHIFT{1'b0}}};
			rb_s1      <= {dv, {SHIFT{1'b0}}};
			rc_s1      <= {dw, {SHIFT{1'b0}}};
			sector_s1  <= sample.sector;
			sin_idx_s1 <= sin_idx;
			cos_idx_s1 <= cos_idx;
			sin_neg_s1 <= quad_sin[1];
			cos_neg_s1 <= quad_cos[1];
		end
	end

	// stage 2: phase reconstruction by sector, table lookup
	logic signed [15:0] a_c2, b_c2, c_c2, sin_c2, cos_c2;
	logic [15:0]        sin_mag, cos_mag;

	always_comb begin
		unique case (sector_s1)
			3'd1, 3'd6: begin
				a_c2 = ra_s1;
				b_c2 = kcl(ra_s1, rc_s1);
				c_c2 = kcl(ra_s1, rb_s1);
			end
			3'd2, 3'd3: begin
				b_c2 = rb_s1;
				a_c2 = kcl(rb_s1, rc_s1);
				c_c2 = kcl(rb_s1, ra_s1);
			end
			3'd4, 3'd5: begin
				c_c2 = rc_s1;
				a_c2 = kcl(rc_s1, rb_s1);
				b_c2 = kcl(rc_s1, ra_s1);
			end
			default: begin
				a_c2 = ra_s1;
				b_c2 = rb_s1;
				c_c2 = rc_s1;
			end
		endcase

		// top index bit set means the full-scale entry (sin = 1.0)
		sin_mag = sin_idx_s1[QUAD_BITS] ? 16'h8000 : sine_rom[sin_idx_s1[QUAD_BITS-1:0]];
		cos_mag = cos_idx_s1[QUAD_BITS] ? 16'h8000 : sine_rom[cos_idx_s1[QUAD_BITS-1:0]];

		// +1.0 clips to 32767, -1.0 keeps 0x8000
		if (sin_neg_s1) begin
			sin_c2 = -$signed(sin_mag);
		end else begin
			sin_c2 = sin_mag[15] ? 16'sh7fff : $signed(sin_mag);
		end
		if (cos_neg_s1) begin
			cos_c2 = -$signed(cos_mag);
		end else begin
			cos_c2 = cos_mag[15] ? 16'sh7fff : $signed(cos_mag);
		end
	end

	logic signed [15:0] a_s2, b_s2, c_s2, sin_s2, cos_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2   <= a_c2;
			b_s2   <= b_c2;
			c_s2   <= c_c2;
			sin_s2 <= sin_c2;
			cos_s2 <= cos_c2;
		end
	end

	// stage 3: beta product coef * (a + 2b)
	logic signed [17:0] ab2;
	logic signed [16:0] coef_s;

	assign ab2    = 18'(a_s2) + (18'(b_s2) <<< 1);
	assign coef_s = $signed({1'b0, coef_q});

	logic signed [15:0] a_s3, b_s3, c_s3, sin_s3, cos_s3;
	logic signed [34:0] beta_prod_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3         <= a_s2;
			b_s3         <= b_s2;
			c_s3         <= c_s2;
			sin_s3       <= sin_s2;
			cos_s3       <= cos_s2;
			beta_prod_s3 <= coef_s * ab2;
		end
	end

	// stage 4: beta saturation, Park products
	logic signed [15:0] beta_c4;

	assign beta_c4 = sat16({beta_prod_s3[34], beta_prod_s3[34:16]});

	logic signed [15:0] a_s4, b_s4, c_s4, beta_s4;
	logic signed [31:0] p_ac_s4, p_bs_s4, p_bc_s4, p_as_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			c_s4    <= c_s3;
			beta_s4 <= beta_c4;
			p_ac_s4 <= a_s3 * cos_s3;
			p_bs_s4 <= beta_c4 * sin_s3;
			p_bc_s4 <= beta_c4 * cos_s3;
			p_as_s4 <= a_s3 * sin_s3;
		end
	end

	// stage 5: d/q sums, floor shift, saturation
	logic signed [32:0] sum_d, sum_q;

	assign sum_d = 33'(p_ac_s4) + 33'(p_bs_s4);
	assign sum_q = 33'(p_bc_s4) - 33'(p_as_s4);

	result_t result_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s5.phase_a            <= a_s4;
			result_s5.phase_b            <= b_s4;
			result_s5.phase_c            <= c_s4;
			result_s5.alpha_current      <= a_s4;
			result_s5.beta_current       <= beta_s4;
			result_s5.direct_current     <= sat16({{2{sum_d[32]}}, sum_d[32:15]});
			result_s5.quadrature_current <= sat16({{2{sum_q[32]}}, sum_q[32:15]});
		end
	end

	assign result = result_s5;

endmodule

`default_nettype wire

@@ sv/pcdq_checker.sv @@
// Port-level checker for the phase current to dq unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pcdq_checker
	import pcdq_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// a held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample stalled without output back-pressure");

	// alpha is the reconstructed U phase
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.alpha_current == result.phase_a)
		else $error("alpha differs from phase a");

	// zero current gives zero beta, d and q at any angle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.phase_a == 16'sd0 && result.phase_b == 16'sd0
		|-> result.beta_current == 16'sd0 && result.direct_current == 16'sd0
			&& result.quadrature_current == 16'sd0)
		else $error("nonzero transform output for zero current");

endmodule

bind phase_current_to_dq_unit pcdq_checker u_pcdq_checker (.*);

`default_nettype wire
